>>> rtl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the light-tracking servo stepper
// Beat payloads, register file image, tracking state and reset values.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_POS_MIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_MAX     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN        = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_TICKS = 3'd4;

    localparam logic [7:0]  RST_POS_MIN     = 8'd40;
    localparam logic [7:0]  RST_POS_MAX     = 8'd192;
    localparam logic [7:0]  RST_DEADBAND    = 8'd14;
    localparam logic [7:0]  RST_GAIN        = 8'd12;
    localparam logic [15:0] RST_FRAME_TICKS = 16'd20000;

    localparam logic [7:0]  RST_POSITION = 8'd112;
    localparam logic [7:0]  RST_VELOCITY = 8'd1;
    localparam logic [7:0]  RST_LAST_REP = 8'd0;
    localparam logic [15:0] RST_HIGH     = 16'd1344;
    localparam logic [15:0] RST_LOW      = 16'd18656;

    typedef struct packed {
        logic [7:0] sample_a;
        logic [7:0] sample_b;
        logic [7:0] sample_c;
        logic [7:0] sample_d;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]  cur_position;
        logic [15:0] high_ticks;
        logic [15:0] low_ticks;
        logic        moved;
        logic        report_valid;
        logic [7:0]  report_byte;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  pos_min;
        logic [7:0]  pos_max;
        logic [7:0]  deadband;
        logic [7:0]  gain;
        logic [15:0] frame_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  position;
        logic [7:0]  velocity;
        logic        dir_up;
        logic        dir_down;
        logic [7:0]  last_reported;
        logic [15:0] high;
        logic [15:0] low;
    } track_state_t;

endpackage

>>> rtl/lts_cfg.sv
// ----------------------------------------------------------------------------
// lts_cfg: configuration register file
// Plain write port; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module lts_cfg
    import lts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_POS_MIN:     cfg_next.pos_min     = wr_data[7:0];
                REG_POS_MAX:     cfg_next.pos_max     = wr_data[7:0];
                REG_DEADBAND:    cfg_next.deadband    = wr_data[7:0];
                REG_GAIN:        cfg_next.gain        = wr_data[7:0];
                REG_FRAME_TICKS: cfg_next.frame_ticks = wr_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_min     <= RST_POS_MIN;
            cfg_reg.pos_max     <= RST_POS_MAX;
            cfg_reg.deadband    <= RST_DEADBAND;
            cfg_reg.gain        <= RST_GAIN;
            cfg_reg.frame_ticks <= RST_FRAME_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lts_step.sv
// ----------------------------------------------------------------------------
// lts_step: one tracking step
// From a sample beat, the register file and the current state, form the next
// state and the result beat.
// ----------------------------------------------------------------------------
module lts_step
    import lts_pkg::*;
(
    input  in_beat_t     beat,
    input  cfg_t         cfg,
    input  track_state_t cur,
    output track_state_t nxt,
    output out_beat_t    result
);

    logic [8:0]  left_sum;
    logic [8:0]  right_sum;
    logic [7:0]  left_mean;
    logic [7:0]  right_mean;
    logic [7:0]  mag;
    logic        go_up;
    logic        go_down;
    logic        in_band;
    logic        report;
    logic [7:0]  vel_new;
    logic [7:0]  cand;
    logic        in_range;
    logic        moved;
    logic [15:0] hi_cand;
    logic [15:0] lo_cand;

    always_comb
    begin
        left_sum   = {1'b0, beat.sample_a} + {1'b0, beat.sample_c};
        right_sum  = {1'b0, beat.sample_b} + {1'b0, beat.sample_d};
        left_mean  = left_sum[8:1];
        right_mean = right_sum[8:1];
        go_up      = right_mean < left_mean;
        go_down    = left_mean < right_mean;
        mag        = go_up ? (left_mean - right_mean) : (right_mean - left_mean);
        in_band    = (mag != 8'd0) && (mag < cfg.deadband);
        report     = in_band && (cur.last_reported != cur.position);

        // velocity keeps growing while the direction repeats, wraps at 8 bits
        if (go_up)
            vel_new = cur.dir_up ? (cur.velocity + 8'd1) : 8'd1;
        else
            vel_new = cur.dir_down ? (cur.velocity + 8'd1) : 8'd1;

        cand     = go_up ? (cur.position + vel_new) : (cur.position - vel_new);
        in_range = (cand >= cfg.pos_min) && (cand <= cfg.pos_max);
        moved    = !in_band && (go_up || go_down) && in_range;
        hi_cand  = {8'd0, cfg.gain} * {8'd0, cand};
        lo_cand  = (cfg.frame_ticks > hi_cand) ? (cfg.frame_ticks - hi_cand) : 16'd0;

        nxt = cur;
        if (report)
            nxt.last_reported = cur.position;
        if (!in_band && (go_up || go_down))
        begin
            nxt.velocity = vel_new;
            nxt.dir_up   = go_up;
            nxt.dir_down = go_down;
        end
        if (moved)
        begin
            nxt.position = cand;
            nxt.high     = hi_cand;
            nxt.low      = lo_cand;
        end

        result.cur_position = nxt.position;
        result.high_ticks   = nxt.high;
        result.low_ticks    = nxt.low;
        result.moved        = moved;
        result.report_valid = report;
        result.report_byte  = report ? cur.position : 8'd0;
    end

endmodule

>>> rtl/light_tracking_servo_stepper.sv
// ----------------------------------------------------------------------------
// light_tracking_servo_stepper: sun-tracking servo stepper
// Input register, one step of tracking logic, result register.
// ----------------------------------------------------------------------------
// Takes one beat of four light samples per clock while in_stall is low and
// returns exactly one result beat per sample beat. The rate is one beat per
// cycle when the output is not stalled, set by the single step stage between
// the input register and the result register; the tracking state is updated
// as a beat moves into the result register, so the next beat already sees it.
// in_stall rises only when both the input register and the result register
// hold beats and the output is stalled. Register writes take effect on the
// next beat that reaches the step logic.
module light_tracking_servo_stepper
    import lts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_beat_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_beat_t              out_data,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t         cfg;
    track_state_t state_reg;
    track_state_t state_next;
    out_beat_t    step_result;

    logic         in_valid_reg;
    in_beat_t     in_data_reg;
    logic         out_valid_reg;
    out_beat_t    out_data_reg;

    logic         out_free;
    logic         advance;
    logic         in_take;

    lts_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    lts_step u_step (
        .beat   (in_data_reg),
        .cfg    (cfg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (step_result)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.position      <= RST_POSITION;
            state_reg.velocity      <= RST_VELOCITY;
            state_reg.dir_up        <= 1'b0;
            state_reg.dir_down      <= 1'b0;
            state_reg.last_reported <= RST_LAST_REP;
            state_reg.high          <= RST_HIGH;
            state_reg.low           <= RST_LOW;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers: load only, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // the result register always holds the newest beat, so it mirrors the state
    a_pos_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.cur_position == state_reg.position)
            && (out_data_reg.high_ticks == state_reg.high)
            && (out_data_reg.low_ticks == state_reg.low))
        else $error("result beat does not match tracking state");

    a_report_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.report_valid |-> !out_data_reg.moved)
        else $error("report and step in the same beat");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.report_valid
            |-> (out_data_reg.report_byte == state_reg.last_reported))
        else $error("reported byte not recorded as last reported");

    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.report_valid |-> (out_data_reg.report_byte == 8'd0))
        else $error("report byte set without report");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("tracking state changed without a step");

endmodule

>>> sim/light_tracking_servo_stepper_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_tracking_servo_stepper_tb: self-checking bench for the servo stepper
// Drives sample beats under random gaps and output stalls, with a mirror of
// the tracking state that predicts every result beat. Register settings are
// changed between phases while the block is idle. They include an inverted
// window, a zero and a full deadband, and saturating pulse widths.
// ----------------------------------------------------------------------------

class servo_step_tracker;
    lts_pkg::cfg_t      cfg;
    logic [7:0]         position;
    logic [7:0]         velocity;
    logic [7:0]         last_sent;
    logic               dir_up;
    logic               dir_down;
    logic [15:0]        high_t;
    logic [15:0]        low_t;
    lts_pkg::out_beat_t expected_beats[$];
    int                 mismatches;
    int                 checked;
    int                 moves;
    int                 refusals;
    int                 reports;

    function new();
        cfg.pos_min     = lts_pkg::RST_POS_MIN;
        cfg.pos_max     = lts_pkg::RST_POS_MAX;
        cfg.deadband    = lts_pkg::RST_DEADBAND;
        cfg.gain        = lts_pkg::RST_GAIN;
        cfg.frame_ticks = lts_pkg::RST_FRAME_TICKS;
        position   = lts_pkg::RST_POSITION;
        velocity   = lts_pkg::RST_VELOCITY;
        last_sent  = lts_pkg::RST_LAST_REP;
        dir_up     = 1'b0;
        dir_down   = 1'b0;
        high_t     = lts_pkg::RST_HIGH;
        low_t      = lts_pkg::RST_LOW;
        mismatches = 0;
        checked    = 0;
        moves      = 0;
        refusals   = 0;
        reports    = 0;
    endfunction

    function void set_reg(logic [lts_pkg::CFG_INDEX_W-1:0] idx,
                          logic [lts_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            lts_pkg::REG_POS_MIN:     cfg.pos_min     = val[7:0];
            lts_pkg::REG_POS_MAX:     cfg.pos_max     = val[7:0];
            lts_pkg::REG_DEADBAND:    cfg.deadband    = val[7:0];
            lts_pkg::REG_GAIN:        cfg.gain        = val[7:0];
            lts_pkg::REG_FRAME_TICKS: cfg.frame_ticks = val;
            default: ;
        endcase
    endfunction

    // Hold position and pulse widths when the candidate leaves the window.
    function bit try_step(logic [7:0] cand);
        logic [15:0] hi;
        if (cand > cfg.pos_max || cand < cfg.pos_min)
        begin
            refusals++;
            return 1'b0;
        end
        hi       = {8'd0, cfg.gain} * {8'd0, cand};
        high_t   = hi;
        low_t    = (cfg.frame_ticks > hi) ? cfg.frame_ticks - hi : 16'd0;
        position = cand;
        moves++;
        return 1'b1;
    endfunction

    function void take_samples(lts_pkg::in_beat_t s);
        int                 left;
        int                 right;
        int                 diff;
        int                 mag;
        lts_pkg::out_beat_t e;
        left  = (int'(s.sample_a) + int'(s.sample_c)) >>> 1;
        right = (int'(s.sample_b) + int'(s.sample_d)) >>> 1;
        diff  = right - left;
        mag   = (diff < 0) ? -diff : diff;
        e     = '0;
        if (diff != 0 && mag < int'(cfg.deadband))
        begin
            if (last_sent != position)
            begin
                e.report_valid = 1'b1;
                e.report_byte  = position;
                last_sent      = position;
                reports++;
            end
        end
        else if (right < left)
        begin
            velocity = dir_up ? velocity + 8'd1 : 8'd1;
            dir_up   = 1'b1;
            dir_down = 1'b0;
            e.moved  = try_step(position + velocity);
        end
        else if (left < right)
        begin
            velocity = dir_down ? velocity + 8'd1 : 8'd1;
            dir_up   = 1'b0;
            dir_down = 1'b1;
            e.moved  = try_step(position - velocity);
        end
        e.cur_position = position;
        e.high_ticks   = high_t;
        e.low_ticks    = low_t;
        expected_beats.push_back(e);
    endfunction

    function void check_beat(lts_pkg::out_beat_t got);
        lts_pkg::out_beat_t e;
        if (expected_beats.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: pos=%0d hi=%0d lo=%0d mv=%0b rv=%0b rb=%0d",
                         got.cur_position, got.high_ticks, got.low_ticks,
                         got.moved, got.report_valid, got.report_byte);
            return;
        end
        e = expected_beats.pop_front();
        checked++;
        if (got.cur_position !== e.cur_position || got.high_ticks !== e.high_ticks ||
            got.low_ticks !== e.low_ticks || got.moved !== e.moved ||
            got.report_valid !== e.report_valid || got.report_byte !== e.report_byte)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("beat %0d exp: pos=%0d hi=%0d lo=%0d mv=%0b rv=%0b rb=%0d",
                         checked, e.cur_position, e.high_ticks, e.low_ticks,
                         e.moved, e.report_valid, e.report_byte);
                $display("beat %0d got: pos=%0d hi=%0d lo=%0d mv=%0b rv=%0b rb=%0d",
                         checked, got.cur_position, got.high_ticks, got.low_ticks,
                         got.moved, got.report_valid, got.report_byte);
            end
        end
    endfunction
endclass

module light_tracking_servo_stepper_tb;
    import lts_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    in_beat_t               in_data  = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_beat_t              out_data;
    logic                   wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0]  wr_data  = '0;

    servo_step_tracker tracker;
    bit                calm   = 1'b0;
    bit                run_up = 1'b1;
    int                beats_sent = 0;

    light_tracking_servo_stepper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_samples(in_data);
            if (out_valid && !out_stall)
                tracker.check_beat(out_data);
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 15);

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("light_tracking_servo_stepper_tb NOT OK");
        $finish;
    end

    task automatic send_beat(in_beat_t b);
        if (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_beats.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        tracker.set_reg(idx, val);
    endtask

    // Upper byte of the 8-bit registers carries junk that must be ignored.
    task automatic load_settings(int pmin, int pmax, int dband, int g, int frame);
        settle();
        write_reg(REG_POS_MIN,     {8'($urandom), 8'(pmin)});
        write_reg(REG_POS_MAX,     {8'($urandom), 8'(pmax)});
        write_reg(REG_DEADBAND,    {8'($urandom), 8'(dband)});
        write_reg(REG_GAIN,        {8'($urandom), 8'(g)});
        write_reg(REG_FRAME_TICKS, 16'(frame));
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Two samples per side whose truncated mean lands on the given value.
    function automatic in_beat_t beat_for(int lmean, int rmean);
        in_beat_t b;
        int       p;
        int       q;
        p = lmean;
        q = (lmean < 255 && $urandom_range(1)) ? lmean + 1 : lmean;
        if ($urandom_range(1))
        begin
            b.sample_a = 8'(p);
            b.sample_c = 8'(q);
        end
        else
        begin
            b.sample_a = 8'(q);
            b.sample_c = 8'(p);
        end
        p = rmean;
        q = (rmean < 255 && $urandom_range(1)) ? rmean + 1 : rmean;
        if ($urandom_range(1))
        begin
            b.sample_b = 8'(p);
            b.sample_d = 8'(q);
        end
        else
        begin
            b.sample_b = 8'(q);
            b.sample_d = 8'(p);
        end
        return b;
    endfunction

    // up: left side brighter by delta.
    function automatic in_beat_t step_beat(int delta, bit up);
        int r;
        r = $urandom_range(255 - delta, 0);
        return up ? beat_for(r + delta, r) : beat_for(r, r + delta);
    endfunction

    function automatic in_beat_t mixed_beat();
        int pick;
        int dband;
        int delta;
        dband = tracker.cfg.deadband;
        if ($urandom_range(7) == 0)
            run_up = !run_up;
        pick = $urandom_range(99);
        if (pick < 25)
            return in_beat_t'($urandom);
        if (pick < 50)
        begin
            delta = $urandom_range((dband + 2 > 255) ? 255 : dband + 2, 0);
            return step_beat(delta, $urandom_range(1));
        end
        delta = $urandom_range(255, dband);
        return step_beat(delta, run_up);
    endfunction

    task automatic run_mixed(int count);
        repeat (count) send_beat(mixed_beat());
    endtask

    initial
    begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: window 40..192, deadband 14, start at 112.
        send_beat(in_beat_t'{8'd0, 8'd0, 8'd0, 8'd0});
        send_beat(in_beat_t'{8'd255, 8'd255, 8'd255, 8'd255});
        send_beat(in_beat_t'{8'd255, 8'd0, 8'd255, 8'd0});
        send_beat(in_beat_t'{8'd255, 8'd0, 8'd255, 8'd0});
        send_beat(in_beat_t'{8'd255, 8'd0, 8'd255, 8'd0});
        send_beat(in_beat_t'{8'd100, 8'd105, 8'd100, 8'd105});
        send_beat(in_beat_t'{8'd100, 8'd105, 8'd100, 8'd105});
        send_beat(in_beat_t'{8'd100, 8'd87, 8'd100, 8'd87});
        send_beat(in_beat_t'{8'd100, 8'd86, 8'd100, 8'd86});
        send_beat(in_beat_t'{8'd0, 8'd255, 8'd0, 8'd255});
        send_beat(in_beat_t'{8'd0, 8'd255, 8'd0, 8'd255});
        send_beat(in_beat_t'{8'd1, 8'd0, 8'd0, 8'd0});
        send_beat(in_beat_t'{8'd255, 8'd254, 8'd254, 8'd255});
        send_beat(in_beat_t'{8'd0, 8'd255, 8'd0, 8'd254});

        // Window of a single position: everything off it is refused.
        load_settings(116, 116, 3, 200, 30000);
        send_beat(in_beat_t'{8'd0, 8'd255, 8'd0, 8'd255});
        send_beat(in_beat_t'{8'd0, 8'd255, 8'd0, 8'd255});
        send_beat(in_beat_t'{8'd10, 8'd12, 8'd10, 8'd12});
        send_beat(in_beat_t'{8'd255, 8'd0, 8'd255, 8'd0});

        load_settings(RST_POS_MIN, RST_POS_MAX, RST_DEADBAND, RST_GAIN, RST_FRAME_TICKS);
        run_mixed(100);

        // Long sweep one way over the full range, no idling on either side:
        // velocity wraps through zero and the candidate wraps around.
        load_settings(0, 255, 0, 255, 65535);
        calm = 1'b1;
        for (int i = 0; i < 270; i++)
        begin
            if ($urandom_range(9) == 0)
                send_beat(step_beat(0, 1'b1));
            else
                send_beat(step_beat($urandom_range(255, 1), 1'b1));
        end
        settle();
        calm = 1'b0;

        // Inverted window: every step refused, full deadband.
        load_settings(200, 50, 255, 0, 0);
        run_mixed(40);

        // Pulse high exceeds the frame, so low saturates.
        load_settings(0, 255, 8, 255, 1000);
        run_mixed(40);
        settle();
        run_mixed(40);

        load_settings($urandom_range(60, 0), $urandom_range(255, 150),
                      $urandom_range(30, 0), 0, 65535);
        run_mixed(60);

        load_settings($urandom_range(255, 0), $urandom_range(255, 0),
                      $urandom_range(40, 0), $urandom_range(255, 0),
                      $urandom_range(65535, 0));
        run_mixed(60);

        settle();
        repeat (4) @(posedge clk);
        if (tracker.expected_beats.size() != 0)
        begin
            tracker.mismatches++;
            $display("%0d predicted beats never arrived", tracker.expected_beats.size());
        end

        $display("sent %0d sample beats over eight register settings, %0d results checked",
                 beats_sent, tracker.checked);
        $display("steps taken %0d, steps refused %0d, position reports %0d, mismatches %0d",
                 tracker.moves, tracker.refusals, tracker.reports, tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("light_tracking_servo_stepper_tb OK");
        else
            $display("light_tracking_servo_stepper_tb NOT OK");
        $finish;
    end
endmodule
